/* hw/rtl/aqh_pkg.sv */
// Shared types and constants of the admin queue host sequencer.
package aqh_pkg;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DISABLE = 3'd1,
        PH_ENABLE  = 3'd2,
        PH_READY   = 3'd3,
        PH_CMD     = 3'd4
    } phase_t;

    // Request modes.
    localparam logic [1:0] MODE_ENABLE   = 2'd0;
    localparam logic [1:0] MODE_TICK     = 2'd1;
    localparam logic [1:0] MODE_SUBMIT   = 2'd2;
    localparam logic [1:0] MODE_COMPLETE = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_REG_WRITE   = 3'd0;
    localparam logic [2:0] KIND_ENABLE_DONE = 3'd1;
    localparam logic [2:0] KIND_ENABLE_FAIL = 3'd2;
    localparam logic [2:0] KIND_ISSUED      = 3'd3;
    localparam logic [2:0] KIND_COMPLETED   = 3'd4;
    localparam logic [2:0] KIND_TIMED_OUT   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CAP_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_DB_STRIDE   = 2'd1;
    localparam logic [1:0] CFG_SQ_BASE     = 2'd2;
    localparam logic [1:0] CFG_CQ_BASE     = 2'd3;

    // Controller register offsets.
    localparam logic [17:0] OFS_CC   = 18'h00014;
    localparam logic [17:0] OFS_AQA  = 18'h00024;
    localparam logic [17:0] OFS_ASQ  = 18'h00028;
    localparam logic [17:0] OFS_ACQ  = 18'h00030;
    localparam logic [17:0] OFS_SQDB = 18'h01000;
    localparam logic [17:0] DB_UNIT  = 18'd4;

    localparam logic [31:0] CC_ENABLE_VALUE = 32'h0046_0001;
    localparam logic [31:0] CSTS_ALL_ONES   = 32'hFFFF_FFFF;

    // Enable timeout: CAP.TO in 500 ms units, default 5000 ms.
    localparam int          CNT_W          = 17;
    localparam logic [16:0] TO_UNIT_MS     = 17'd500;
    localparam logic [16:0] TO_DEFAULT_MS  = 17'd5000;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] cc_value;
        logic [31:0] csts_value;
        logic [15:0] wait_limit;
        logic [15:0] cq_status_word;
        logic [31:0] cq_result;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [17:0] reg_offset;
        logic [63:0] reg_data;
        logic [15:0] cmd_id;
        logic [4:0]  slot;
        logic [14:0] status_code;
        logic [31:0] completion_value;
        logic        last;
    } rsp_t;

    // Up to four results caused by one request.
    typedef struct packed {
        rsp_t [MAX_RESULTS-1:0] ent;
        logic [2:0]             cnt;
    } bundle_t;

    typedef struct packed {
        logic [7:0]  cap_timeout;
        logic [3:0]  doorbell_stride_exp;
        logic [63:0] admin_sq_base;
        logic [63:0] admin_cq_base;
    } cfg_t;

    // Control state apart from the queue pointers.
    typedef struct packed {
        phase_t            phase;
        logic [CNT_W-1:0]  elapsed;
        logic [15:0]       active_limit;
        logic              expected_phase;
        logic [15:0]       next_cmd_id;
    } ctl_state_t;

endpackage

/* hw/rtl/aqh_step.sv */
// Next-state and result logic for one request of the admin queue sequencer.
module aqh_step #(
    parameter int QUEUE_DEPTH = 32
) (
    input  aqh_pkg::req_t                     item,
    input  aqh_pkg::ctl_state_t               st,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    sq_tail,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    cq_head,
    input  aqh_pkg::cfg_t                     cfg,
    output aqh_pkg::ctl_state_t               st_next,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    sq_tail_next,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    cq_head_next,
    output aqh_pkg::bundle_t                  bundle
);
    import aqh_pkg::*;

    localparam int          PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [15:0] Q1    = 16'(QUEUE_DEPTH - 1);

    function automatic rsp_t mk(input logic [2:0] kind, input logic [17:0] ofs,
                                input logic [63:0] data, input logic [15:0] cid,
                                input logic [4:0] slot, input logic [14:0] sts,
                                input logic [31:0] val);
        rsp_t r;
        r.kind             = kind;
        r.reg_offset       = ofs;
        r.reg_data         = data;
        r.cmd_id           = cid;
        r.slot             = slot;
        r.status_code      = sts;
        r.completion_value = val;
        r.last             = 1'b0;
        return r;
    endfunction

    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] enable_to;
    logic             rdy;
    logic             cfs;
    logic             all_ones;
    logic [15:0]      cur_cid;
    logic [PTR_W-1:0] tail_inc;
    logic [PTR_W-1:0] head_inc;
    logic [17:0]      cqdb_ofs;

    assign cnt_inc   = (&st.elapsed) ? st.elapsed : st.elapsed + CNT_W'(1);
    assign enable_to = (cfg.cap_timeout == 8'd0) ? TO_DEFAULT_MS
                       : CNT_W'(cfg.cap_timeout) * TO_UNIT_MS;
    assign rdy       = item.csts_value[0];
    assign cfs       = item.csts_value[1];
    assign all_ones  = (item.csts_value == CSTS_ALL_ONES);
    assign cur_cid   = st.next_cmd_id - 16'd1;
    assign tail_inc  = (sq_tail == PTR_LAST) ? '0 : sq_tail + PTR_W'(1);
    assign head_inc  = (cq_head == PTR_LAST) ? '0 : cq_head + PTR_W'(1);
    assign cqdb_ofs  = OFS_SQDB + (DB_UNIT << cfg.doorbell_stride_exp);

    always_comb
    begin
        st_next      = st;
        sq_tail_next = sq_tail;
        cq_head_next = cq_head;
        bundle       = '0;

        case (item.mode)
            MODE_ENABLE:
            begin
                // Clear CC.EN first if it is set, then wait for RDY to drop.
                if (item.cc_value[0])
                begin
                    bundle.ent[0] = mk(KIND_REG_WRITE, OFS_CC,
                                       64'({item.cc_value[31:1], 1'b0}),
                                       '0, '0, '0, '0);
                    bundle.cnt    = 3'd1;
                end
                st_next.phase   = PH_DISABLE;
                st_next.elapsed = '0;
            end
            MODE_TICK:
            begin
                case (st.phase)
                    PH_DISABLE:
                    begin
                        if (all_ones || (rdy && cfs))
                        begin
                            bundle.ent[0] = mk(KIND_ENABLE_FAIL, '0, '0, '0, '0, '0, '0);
                            bundle.cnt    = 3'd1;
                            st_next.phase = PH_IDLE;
                        end
                        else if (!rdy)
                        begin
                            bundle.ent[0] = mk(KIND_REG_WRITE, OFS_AQA, 64'({Q1, Q1}),
                                               '0, '0, '0, '0);
                            bundle.ent[1] = mk(KIND_REG_WRITE, OFS_ASQ, cfg.admin_sq_base,
                                               '0, '0, '0, '0);
                            bundle.ent[2] = mk(KIND_REG_WRITE, OFS_ACQ, cfg.admin_cq_base,
                                               '0, '0, '0, '0);
                            bundle.ent[3] = mk(KIND_REG_WRITE, OFS_CC, 64'(CC_ENABLE_VALUE),
                                               '0, '0, '0, '0);
                            bundle.cnt             = 3'd4;
                            sq_tail_next           = '0;
                            cq_head_next           = '0;
                            st_next.expected_phase = 1'b1;
                            st_next.next_cmd_id    = '0;
                            st_next.elapsed        = '0;
                            st_next.phase          = PH_ENABLE;
                        end
                        else
                        begin
                            st_next.elapsed = cnt_inc;
                            if (cnt_inc > enable_to)
                            begin
                                bundle.ent[0] = mk(KIND_ENABLE_FAIL, '0, '0, '0, '0, '0, '0);
                                bundle.cnt    = 3'd1;
                                st_next.phase = PH_IDLE;
                            end
                        end
                    end
                    PH_ENABLE:
                    begin
                        if (all_ones)
                        begin
                            bundle.ent[0] = mk(KIND_ENABLE_FAIL, '0, '0, '0, '0, '0, '0);
                            bundle.cnt    = 3'd1;
                            st_next.phase = PH_IDLE;
                        end
                        else if (rdy)
                        begin
                            bundle.ent[0] = mk(KIND_ENABLE_DONE, '0, '0, '0, '0, '0, '0);
                            bundle.cnt    = 3'd1;
                            st_next.phase = PH_READY;
                        end
                        else if (cfs)
                        begin
                            bundle.ent[0] = mk(KIND_ENABLE_FAIL, '0, '0, '0, '0, '0, '0);
                            bundle.cnt    = 3'd1;
                            st_next.phase = PH_IDLE;
                        end
                        else
                        begin
                            st_next.elapsed = cnt_inc;
                            if (cnt_inc > enable_to)
                            begin
                                bundle.ent[0] = mk(KIND_ENABLE_FAIL, '0, '0, '0, '0, '0, '0);
                                bundle.cnt    = 3'd1;
                                st_next.phase = PH_IDLE;
                            end
                        end
                    end
                    PH_CMD:
                    begin
                        st_next.elapsed = cnt_inc;
                        if (cnt_inc > CNT_W'(st.active_limit))
                        begin
                            bundle.ent[0] = mk(KIND_TIMED_OUT, '0, '0, cur_cid, '0, '0, '0);
                            bundle.cnt    = 3'd1;
                            st_next.phase = PH_READY;
                        end
                    end
                    default:
                    begin
                        st_next = st;
                    end
                endcase
            end
            MODE_SUBMIT:
            begin
                if (st.phase == PH_READY)
                begin
                    bundle.ent[0] = mk(KIND_ISSUED, '0, '0, st.next_cmd_id,
                                       5'(sq_tail), '0, '0);
                    bundle.ent[1] = mk(KIND_REG_WRITE, OFS_SQDB, 64'(tail_inc),
                                       '0, '0, '0, '0);
                    bundle.cnt           = 3'd2;
                    sq_tail_next         = tail_inc;
                    st_next.next_cmd_id  = st.next_cmd_id + 16'd1;
                    st_next.active_limit = item.wait_limit;
                    st_next.elapsed      = '0;
                    st_next.phase        = PH_CMD;
                end
            end
            default:
            begin
                // Completion sample: take it only in the command wait and when the phase tag matches.
                if (st.phase == PH_CMD && item.cq_status_word[0] == st.expected_phase)
                begin
                    bundle.ent[0] = mk(KIND_COMPLETED, '0, '0, cur_cid, '0,
                                       item.cq_status_word[15:1], item.cq_result);
                    bundle.ent[1] = mk(KIND_REG_WRITE, cqdb_ofs, 64'(head_inc),
                                       '0, '0, '0, '0);
                    bundle.cnt    = 3'd2;
                    cq_head_next  = head_inc;
                    if (cq_head == PTR_LAST)
                    begin
                        st_next.expected_phase = ~st.expected_phase;
                    end
                    st_next.phase = PH_READY;
                end
            end
        endcase

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (bundle.cnt != 3'd0 && 3'(i) == bundle.cnt - 3'd1)
            begin
                bundle.ent[i].last = 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/aqh_rsp_buf.sv */
// Result register that holds the results of one request and drains them in order.
module aqh_rsp_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  aqh_pkg::bundle_t bundle,
    input  logic             load,
    output logic             can_load,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output aqh_pkg::rsp_t    rsp
);
    import aqh_pkg::*;

    rsp_t [MAX_RESULTS-1:0] ent_reg;
    logic [2:0]             cnt_reg;
    logic [2:0]             cnt_next;
    logic [1:0]             idx_reg;
    logic [1:0]             idx_next;
    logic                   take;
    logic                   take_last;

    assign rsp_valid = (cnt_reg != 3'd0);
    assign rsp       = ent_reg[idx_reg];
    assign take      = rsp_valid && !rsp_stall;
    assign take_last = take && (3'(idx_reg) == cnt_reg - 3'd1);
    assign can_load  = !rsp_valid || take_last;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = bundle.cnt;
            idx_next = '0;
        end
        else if (take_last)
        begin
            cnt_next = '0;
            idx_next = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= bundle.ent;
        end
    end

endmodule

/* hw/rtl/nvme_admin_queue_host_sequencer_unit.sv */
// Top level of the NVMe admin queue host sequencer.
// A request is registered at acceptance; its results load into the result register when free.
// One request per cycle while each request yields at most one result and rsp_stall is low; a
// request with more results holds the single result register, one result per unstalled cycle.
// Reset: all control state clears at once (phase idle, pointers and counts zero, expected
// completion phase one, configuration zero); there is no clearing pass.
module nvme_admin_queue_host_sequencer_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    // Request channel
    input  logic           req_valid,
    output logic           req_stall,
    input  aqh_pkg::req_t  req,
    // Result channel
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output aqh_pkg::rsp_t  rsp,
    // Configuration writes
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [63:0]    cfg_data
);
    import aqh_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    // Request register stage.
    req_t             item_reg;
    logic             item_vld_reg;
    logic             item_vld_next;
    logic             accept;
    logic             advance;

    // Sequencer state.
    ctl_state_t       st_reg;
    ctl_state_t       st_next;
    logic [PTR_W-1:0] sq_tail_reg;
    logic [PTR_W-1:0] sq_tail_next;
    logic [PTR_W-1:0] cq_head_reg;
    logic [PTR_W-1:0] cq_head_next;

    // Configuration registers.
    cfg_t             cfg_reg;
    cfg_t             cfg_next;

    bundle_t          bundle;
    logic             can_load;

    // Hold the registered request until the result register can take its results.
    assign advance   = item_vld_reg && can_load;
    assign req_stall = item_vld_reg && !can_load;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (accept)
        begin
            item_vld_next = 1'b1;
        end
        else if (advance)
        begin
            item_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
    end

    // Decode configuration writes; fields narrower than the data bus drop upper bits.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAP_TIMEOUT: cfg_next.cap_timeout         = cfg_data[7:0];
                CFG_DB_STRIDE:   cfg_next.doorbell_stride_exp = cfg_data[3:0];
                CFG_SQ_BASE:     cfg_next.admin_sq_base       = cfg_data;
                CFG_CQ_BASE:     cfg_next.admin_cq_base       = cfg_data;
                default:         cfg_next                     = cfg_reg;
            endcase
        end
    end

    // Evaluate the registered request against the current state in one pass.
    aqh_step #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_step (
        .item         (item_reg),
        .st           (st_reg),
        .sq_tail      (sq_tail_reg),
        .cq_head      (cq_head_reg),
        .cfg          (cfg_reg),
        .st_next      (st_next),
        .sq_tail_next (sq_tail_next),
        .cq_head_next (cq_head_next),
        .bundle       (bundle)
    );

    // Advance the state only when the request leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg          <= 1'b0;
            st_reg.phase          <= PH_IDLE;
            st_reg.elapsed        <= '0;
            st_reg.active_limit   <= '0;
            st_reg.expected_phase <= 1'b1;
            st_reg.next_cmd_id    <= '0;
            sq_tail_reg           <= '0;
            cq_head_reg           <= '0;
            cfg_reg               <= '0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            cfg_reg      <= cfg_next;
            if (advance)
            begin
                st_reg      <= st_next;
                sq_tail_reg <= sq_tail_next;
                cq_head_reg <= cq_head_next;
            end
        end
    end

    // Result register: a request with no results loads nothing.
    aqh_rsp_buf u_rsp_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .bundle    (bundle),
        .load      (advance && bundle.cnt != 3'd0),
        .can_load  (can_load),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Queue pointers stay inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sq_tail_reg <= PTR_W'(QUEUE_DEPTH - 1)) && (cq_head_reg <= PTR_W'(QUEUE_DEPTH - 1)))
        else $error("queue pointer out of range");

    // A stall toward the requester comes only from a held request.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> item_vld_reg)
        else $error("request stalled with empty input register");

    // An issued command is always followed by its doorbell write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind == KIND_ISSUED) |-> !rsp.last)
        else $error("issued result marked last");

    // A submit taken in the ready phase moves to the command wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.mode == MODE_SUBMIT && st_reg.phase == PH_READY)
        |=> (st_reg.phase == PH_CMD))
        else $error("submit did not start command wait");

    // Completion results only leave the command wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && bundle.cnt != 3'd0 && bundle.ent[0].kind == KIND_COMPLETED)
        |-> (st_reg.phase == PH_CMD))
        else $error("completion outside command wait");

endmodule
